// File: src/ppg_pkg.sv
// shared constants, types and the quarter-wave sine table of the plasma generator
package ppg_pkg;

	localparam int COORD_W      = 11;
	localparam int PHASE_W      = 16;
	localparam int DIM_W        = 12;
	localparam int PIX_W        = 8;
	localparam int IN_DATA_W    = ((2 * COORD_W + 7) / 8) * 8;

	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
	localparam int SINE_HALF    = SINE_ENTRIES / 2;
	localparam int SINE_QTR     = SINE_ENTRIES / 4;
	localparam int QTR_IDX_W    = $clog2(SINE_QTR + 1);
	localparam int MAG_W        = 7;
	localparam int SINE_W       = MAG_W + 1;
	localparam int SINE_AMP     = 127;

	localparam int SUM_W        = 10;
	localparam logic signed [SUM_W:0] SUM_BIAS = (SUM_W + 1)'(4 * SINE_AMP);

	localparam int MUL_X        = 1490;
	localparam int MUL_Y        = 2086;
	localparam int MUL_XY       = 1738;
	localparam int MUL_R        = 163;

	localparam int SQ_W         = 2 * COORD_W;
	localparam int RAD_SHIFT    = 8;
	localparam int RAD_W        = SQ_W + 1 + RAD_SHIFT;
	localparam int ROOT_W       = (RAD_W + 1) / 2;
	localparam int ACC_W        = RAD_W + 1;

	localparam int FRONT_STAGES = 2;
	localparam int BACK_STAGES  = 3;

	localparam int APB_ADDR_W   = 4;
	localparam int APB_DATA_W   = 32;
	localparam logic [1:0] REG_TIME_PHASE   = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;
	localparam logic [PHASE_W-1:0] TIME_PHASE_RST   = '0;
	localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 12'd256;
	localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 12'd256;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef logic [MAG_W-1:0] sine_mag_t [SINE_QTR+1];

	typedef struct packed {
		logic [SUM_W-1:0]   part;
		logic [PHASE_W-1:0] t;
		logic               row_end;
		logic               frame_end;
	} side_t;

	// round(127*sin) over the first quarter turn, taylor series in q30
	function automatic sine_mag_t build_sine_mag();
		sine_mag_t       tab;
		longint unsigned a;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          acc;
		for (int q = 0; q <= SINE_QTR; q++) begin
			a = longint'(4 * q);
			if (3 * a == longint'(SINE_ENTRIES)) begin
				v = 64;
			end else begin
				x    = (PI_Q30 * a) >> (SINE_IDX_W + 1);
				x2   = (x * x) >> 30;
				term = x;
				acc  = longint'(x);
				term = ((term * x2) >> 30) / 6;
				acc  = acc - longint'(term);
				term = ((term * x2) >> 30) / 20;
				acc  = acc + longint'(term);
				term = ((term * x2) >> 30) / 42;
				acc  = acc - longint'(term);
				term = ((term * x2) >> 30) / 72;
				acc  = acc + longint'(term);
				term = ((term * x2) >> 30) / 110;
				acc  = acc - longint'(term);
				term = ((term * x2) >> 30) / 156;
				acc  = acc + longint'(term);
				term = ((term * x2) >> 30) / 210;
				acc  = acc - longint'(term);
				term = ((term * x2) >> 30) / 272;
				acc  = acc + longint'(term);
				if (acc < 0) acc = 0;
				if (longint'(ONE_Q30) < acc) acc = longint'(ONE_Q30);
				v = (longint'(SINE_AMP) * longint'(acc) + (ONE_Q30 >> 1)) >> 30;
			end
			tab[q] = MAG_W'(v);
		end
		return tab;
	endfunction

	localparam sine_mag_t SINE_MAG = build_sine_mag();

endpackage

// File: src/ppg_sine_lookup.sv
// phase to signed sine: quarter-wave fold and table read
module ppg_sine_lookup (
	input  logic [ppg_pkg::PHASE_W-1:0]       phase,
	output logic signed [ppg_pkg::SINE_W-1:0] sine
);
	import ppg_pkg::*;

	logic [SINE_IDX_W-1:0] idx;
	logic [SINE_IDX_W:0]   fold1;
	logic [SINE_IDX_W:0]   fold2;
	logic                  neg;
	logic [MAG_W-1:0]      mag;

	assign idx = phase[PHASE_W-1 -: SINE_IDX_W];

	always_comb begin
		neg   = {1'b0, idx} > (SINE_IDX_W + 1)'(SINE_HALF);
		fold1 = neg ? (SINE_IDX_W + 1)'(SINE_ENTRIES) - {1'b0, idx} : {1'b0, idx};
		// second half of a half turn mirrors the first
		fold2 = (fold1 > (SINE_IDX_W + 1)'(SINE_QTR)) ?
			(SINE_IDX_W + 1)'(SINE_HALF) - fold1 : fold1;
		mag   = SINE_MAG[fold2[QTR_IDX_W-1:0]];
		sine  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

// File: src/ppg_front.sv
// front stages: squares, three linear phases, their sines and the edge flags
module ppg_front (
	input  logic                                 clk,
	input  logic [ppg_pkg::FRONT_STAGES-1:0]     en,
	input  logic [ppg_pkg::COORD_W-1:0]          pixel_x,
	input  logic [ppg_pkg::COORD_W-1:0]          pixel_y,
	input  logic [ppg_pkg::PHASE_W-1:0]          time_phase,
	input  logic [ppg_pkg::DIM_W-1:0]            frame_width,
	input  logic [ppg_pkg::DIM_W-1:0]            frame_height,
	output logic [ppg_pkg::RAD_W-1:0]            rad,
	output ppg_pkg::side_t                       side
);
	import ppg_pkg::*;

	logic [COORD_W:0]   xy_sum;
	logic               row_end;

	logic [SQ_W-1:0]    xx_s1;
	logic [SQ_W-1:0]    yy_s1;
	logic [PHASE_W-1:0] ph_x_s1;
	logic [PHASE_W-1:0] ph_y_s1;
	logic [PHASE_W-1:0] ph_xy_s1;
	logic [PHASE_W-1:0] t_s1;
	logic               row_end_s1;
	logic               frame_end_s1;

	logic signed [SINE_W-1:0] sine_x;
	logic signed [SINE_W-1:0] sine_y;
	logic signed [SINE_W-1:0] sine_xy;

	logic [RAD_W-1:0]         rad_s2;
	logic signed [SINE_W-1:0] sine_x_s2;
	logic signed [SINE_W-1:0] sine_y_s2;
	logic signed [SINE_W-1:0] sine_xy_s2;
	logic [PHASE_W-1:0]       t_s2;
	logic                     row_end_s2;
	logic                     frame_end_s2;

	logic [SQ_W:0]            sq_sum;
	logic signed [SUM_W:0]    psum;

	assign xy_sum  = (COORD_W + 1)'(pixel_x) + (COORD_W + 1)'(pixel_y);
	assign row_end = ((DIM_W)'(pixel_x) + DIM_W'(1)) == frame_width;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xx_s1        <= SQ_W'(pixel_x) * SQ_W'(pixel_x);
			yy_s1        <= SQ_W'(pixel_y) * SQ_W'(pixel_y);
			ph_x_s1      <= PHASE_W'(pixel_x * MUL_X) + time_phase;
			ph_y_s1      <= PHASE_W'(pixel_y * MUL_Y) - time_phase;
			ph_xy_s1     <= PHASE_W'(xy_sum * MUL_XY) - time_phase;
			t_s1         <= time_phase;
			row_end_s1   <= row_end;
			frame_end_s1 <= row_end &&
				(((DIM_W)'(pixel_y) + DIM_W'(1)) == frame_height);
		end
	end

	ppg_sine_lookup u_sine_x  (.phase(ph_x_s1),  .sine(sine_x));
	ppg_sine_lookup u_sine_y  (.phase(ph_y_s1),  .sine(sine_y));
	ppg_sine_lookup u_sine_xy (.phase(ph_xy_s1), .sine(sine_xy));

	assign sq_sum = (SQ_W + 1)'(xx_s1) + (SQ_W + 1)'(yy_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			rad_s2       <= {sq_sum, {RAD_SHIFT{1'b0}}};
			sine_x_s2    <= sine_x;
			sine_y_s2    <= sine_y;
			sine_xy_s2   <= sine_xy;
			t_s2         <= t_s1;
			row_end_s2   <= row_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	// bias plus three sines always lands in 127..889
	assign psum = SUM_BIAS + (SUM_W + 1)'(sine_x_s2) + (SUM_W + 1)'(sine_y_s2)
		+ (SUM_W + 1)'(sine_xy_s2);

	assign rad            = rad_s2;
	assign side.part      = psum[SUM_W-1:0];
	assign side.t         = t_s2;
	assign side.row_end   = row_end_s2;
	assign side.frame_end = frame_end_s2;

endmodule

// File: src/ppg_isqrt.sv
// pipelined integer square root, one root bit per stage
module ppg_isqrt (
	input  logic                          clk,
	input  logic [ppg_pkg::ROOT_W-1:0]    en,
	input  logic [ppg_pkg::RAD_W-1:0]     rad,
	input  ppg_pkg::side_t                side_in,
	output logic [ppg_pkg::ROOT_W-1:0]    root,
	output ppg_pkg::side_t                side_out
);
	import ppg_pkg::*;

	logic [RAD_W-1:0] rem_s  [ROOT_W];
	logic [ACC_W-1:0] res_s  [ROOT_W];
	side_t            side_s [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (ROOT_W - 1 - i));

		logic [RAD_W-1:0] cur_rem;
		logic [ACC_W-1:0] cur_res;
		side_t            cur_side;
		logic [ACC_W-1:0] trial;
		logic             take;

		if (i == 0) begin : g_first
			assign cur_rem  = rad;
			assign cur_res  = '0;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_rem  = rem_s[i-1];
			assign cur_res  = res_s[i-1];
			assign cur_side = side_s[i-1];
		end

		assign trial = cur_res + BIT;
		assign take  = ACC_W'(cur_rem) >= trial;

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i]  <= take ? RAD_W'(ACC_W'(cur_rem) - trial) : cur_rem;
				res_s[i]  <= take ? (cur_res >> 1) + BIT : cur_res >> 1;
				side_s[i] <= cur_side;
			end
		end
	end

	assign root     = res_s[ROOT_W-1][ROOT_W-1:0];
	assign side_out = side_s[ROOT_W-1];

endmodule

// File: src/ppg_back.sv
// back stages: radial phase, its sine, final sum and output register
module ppg_back (
	input  logic                              clk,
	input  logic [ppg_pkg::BACK_STAGES-1:0]   en,
	input  logic [ppg_pkg::ROOT_W-1:0]        root,
	input  ppg_pkg::side_t                    side_in,
	output logic [ppg_pkg::PIX_W-1:0]         pixel_value,
	output logic                              row_end,
	output logic                              frame_end
);
	import ppg_pkg::*;

	logic [PHASE_W-1:0]       ph_r_s1;
	side_t                    side_s1;
	logic signed [SINE_W-1:0] sine_r;
	logic signed [SINE_W-1:0] sine_r_s2;
	logic [SUM_W-1:0]         part_s2;
	logic                     row_end_s2;
	logic                     frame_end_s2;
	logic signed [SUM_W:0]    total;
	logic [PIX_W-1:0]         pixel_s3;
	logic                     row_end_s3;
	logic                     frame_end_s3;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ph_r_s1 <= PHASE_W'(root * MUL_R) - side_in.t;
			side_s1 <= side_in;
		end
	end

	ppg_sine_lookup u_sine_r (.phase(ph_r_s1), .sine(sine_r));

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sine_r_s2    <= sine_r;
			part_s2      <= side_s1.part;
			row_end_s2   <= side_s1.row_end;
			frame_end_s2 <= side_s1.frame_end;
		end
	end

	// sum of four biased sines, 0..1016, then floor divide by four
	assign total = $signed({1'b0, part_s2}) + (SUM_W + 1)'(sine_r_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pixel_s3     <= total[SUM_W-1:2];
			row_end_s3   <= row_end_s2;
			frame_end_s3 <= frame_end_s2;
		end
	end

	assign pixel_value = pixel_s3;
	assign row_end     = row_end_s3;
	assign frame_end   = frame_end_s3;

endmodule

// File: src/plasma_pixel_generator_top.sv
// Plasma pixel generator: takes one coordinate beat per clock and returns one grey value beat
// per clock while the output is not held. Each coordinate passes through two front stages
// (squares, linear phases and their sines), a 16-stage square root that yields one bit of
// the radius per stage, and three back stages (radial phase, its sine, final sum). Each
// stage has its own valid bit; a held output stalls only the stages that hold data, so
// empty stages keep filling. m_tlast marks the last column of a row and m_tuser marks the
// last pixel of the frame. Registers on the APB port: 0x0 time_phase, 0x4 frame_width,
// 0x8 frame_height; write them while no pixel is in flight.
module plasma_pixel_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: pixel_x [10:0], pixel_y [21:11], zero [23:22]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ppg_pkg::IN_DATA_W-1:0]     s_tdata,
	// m_tdata: pixel_value [7:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ppg_pkg::PIX_W-1:0]         m_tdata,
	output logic                              m_tlast,
	// m_tuser: frame_end [0]
	output logic [0:0]                        m_tuser,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ppg_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ppg_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ppg_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import ppg_pkg::*;

	localparam int NST = FRONT_STAGES + ROOT_W + BACK_STAGES;

	logic [PHASE_W-1:0] time_phase_q;
	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;
	logic               cfg_wr;
	logic [1:0]         reg_sel;

	logic [NST-1:0]     stg_vld_q;
	logic [NST:0]       stg_en;

	logic [RAD_W-1:0]   rad;
	side_t              side_front;
	side_t              side_root;
	logic [ROOT_W-1:0]  root;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_phase_q   <= TIME_PHASE_RST;
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_TIME_PHASE:   time_phase_q   <= pwdata[PHASE_W-1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_TIME_PHASE:   prdata = APB_DATA_W'(time_phase_q);
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// a stage loads when it is empty or its successor loads
	assign stg_en[NST] = m_tready;
	for (genvar k = 0; k < NST; k++) begin : g_ctl
		assign stg_en[k] = !stg_vld_q[k] || stg_en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_vld_q[k] <= 1'b0;
			end else if (stg_en[k]) begin
				stg_vld_q[k] <= (k == 0) ? s_tvalid : stg_vld_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign s_tready = stg_en[0];
	assign m_tvalid = stg_vld_q[NST-1];

	ppg_front u_front (
		.clk          (clk),
		.en           (stg_en[FRONT_STAGES-1:0]),
		.pixel_x      (s_tdata[COORD_W-1:0]),
		.pixel_y      (s_tdata[2*COORD_W-1:COORD_W]),
		.time_phase   (time_phase_q),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.rad          (rad),
		.side         (side_front)
	);

	ppg_isqrt u_isqrt (
		.clk      (clk),
		.en       (stg_en[FRONT_STAGES +: ROOT_W]),
		.rad      (rad),
		.side_in  (side_front),
		.root     (root),
		.side_out (side_root)
	);

	ppg_back u_back (
		.clk         (clk),
		.en          (stg_en[FRONT_STAGES + ROOT_W +: BACK_STAGES]),
		.root        (root),
		.side_in     (side_root),
		.pixel_value (m_tdata),
		.row_end     (m_tlast),
		.frame_end   (m_tuser[0])
	);

endmodule

// File: src/ppg_checker.sv
// port-level checks on the plasma generator, bound to the top level
module ppg_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tready,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [ppg_pkg::PIX_W-1:0]         m_tdata,
	input  logic                              m_tlast,
	input  logic [0:0]                        m_tuser
);
	import ppg_pkg::*;

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result beat changed while held");

	// the last pixel of a frame is always the last of its row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("frame end without row end");

	// four biased sines over four never reach 255
	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != {PIX_W{1'b1}})
		else $error("pixel value out of range");

	// with the output register empty the whole pipeline can advance
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind plasma_pixel_generator_top ppg_checker u_ppg_checker (.*);
